### rtl/mtse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtse_pkg
// Shared widths, register indexes and magnitude helpers for the
// motion-triggered sample encoder.
// ----------------------------------------------------------------------------
package mtse_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ACCEL_W  = 18;
	localparam int JERK_W   = 19;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 19;

	typedef logic [SAMPLE_W-1:0]   word_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_THR = 1'b0,
		REG_JERK_THR  = 1'b1
	} cfg_reg_t;

	// Magnitude of a signed value. The most negative code maps to its true
	// magnitude, which still fits the unsigned result of the same width.
	function automatic logic [ACCEL_W-1:0] accel_mag(logic signed [ACCEL_W-1:0] v);
		return v[ACCEL_W-1] ? ACCEL_W'(-v) : ACCEL_W'(v);
	endfunction

	function automatic logic [JERK_W-1:0] jerk_mag(logic signed [JERK_W-1:0] v);
		return v[JERK_W-1] ? JERK_W'(-v) : JERK_W'(v);
	endfunction

endpackage

### rtl/mtse_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtse channel interfaces
// Sample input, record output and register write channels, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface mtse_sample_if import mtse_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

interface mtse_record_if import mtse_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t seq_number;
	word_t value_word;
	word_t delta_word;
	logic  prev_flag;
	logic  last_copy;

	modport source (output valid, output seq_number, output value_word,
		output delta_word, output prev_flag, output last_copy, input ready);
	modport sink   (input valid, input seq_number, input value_word,
		input delta_word, input prev_flag, input last_copy, output ready);
endinterface

interface mtse_cfg_if import mtse_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/motion_triggered_sample_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_triggered_sample_encoder
// Turns each 16-bit sample into a record (sequence, value, delta, has-previous)
// and sends it twice when acceleration or jerk magnitude crosses its threshold.
// ----------------------------------------------------------------------------
// A sample is first held in the input register and then moves into the result
// register, from which its record beats are offered.
// Throughput: one sample per cycle when it gives a single record and the output
// is not stalled; a sample that triggers a duplicate holds the result register
// until both copies have left. Reset: arst_n clears thresholds, history, sequence
// counter and both valid flags at once; the block is ready at once after release.
module motion_triggered_sample_encoder import mtse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mtse_cfg_if.sink      cfg,
	mtse_sample_if.sink   sample,
	mtse_record_if.source record
);

	// Threshold registers. The user must write them only while the block is idle;
	// the block does not enforce this. Writes are always accepted (cfg.ready is tied high).
	logic [ACCEL_W-1:0] accel_thr_q;
	logic [JERK_W-1:0]  jerk_thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_thr_q <= '0;
			jerk_thr_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ACCEL_THR: accel_thr_q <= cfg.data[ACCEL_W-1:0];
				REG_JERK_THR:  jerk_thr_q  <= cfg.data[JERK_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register. A new sample is taken whenever the register is empty or
	// its content moves on into the result register in the same cycle.
	logic  valid_s1;
	word_t value_s1;

	// Result register. dup_s2 is set while the first of two copies is on the
	// output; that beat carries last_copy low.
	logic  valid_s2;
	logic  dup_s2;
	word_t seq_s2;
	word_t value_s2;
	word_t delta_s2;
	logic  prev_s2;

	logic s2_free;
	logic s1_adv;

	assign s2_free      = !valid_s2 || (record.ready && !dup_s2);
	assign s1_adv       = valid_s1 && s2_free;
	assign sample.ready = !valid_s1 || s2_free;

	// Motion history carried from one sample to the next.
	word_t                     next_seq_q;
	word_t                     prev_val_q;
	logic                      have_prev_q;
	logic signed [SAMPLE_W-1:0] last_vel_q;
	logic signed [ACCEL_W-1:0]  last_acc_q;
	logic signed [JERK_W-1:0]   last_jerk_q;
	logic [1:0]                warm_q;

	// Velocity is the wrapped difference read as signed. Acceleration and jerk
	// are each one subtract wider than the value before them, so they never
	// overflow.
	word_t                      delta;
	logic signed [SAMPLE_W-1:0] velocity;
	logic signed [ACCEL_W-1:0]  accel;
	logic signed [JERK_W-1:0]   jerk;
	logic                       accel_hit;
	logic                       jerk_hit;
	logic                       dup;

	always_comb begin
		delta    = value_s1 - prev_val_q;
		velocity = $signed(delta);
		accel    = ACCEL_W'(velocity) - ACCEL_W'(last_vel_q);
		jerk     = JERK_W'(accel) - JERK_W'(last_acc_q);
		// An upward crossing: at or above the level now, below it last time.
		accel_hit = (accel_thr_q != '0) && (accel_mag(accel) >= accel_thr_q)
			&& (accel_mag(last_acc_q) < accel_thr_q);
		jerk_hit  = (jerk_thr_q != '0) && (jerk_mag(jerk) >= jerk_thr_q)
			&& (jerk_mag(last_jerk_q) < jerk_thr_q);
		// Two warm-up samples must pass before a duplicate is possible.
		dup = warm_q[1] && (accel_hit || jerk_hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			value_s1 <= sample.sample_value;
		end
	end

	// History advances once per sample as it leaves the input register. The
	// first sample stores no velocity, and the first two store no acceleration
	// or jerk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q  <= '0;
			prev_val_q  <= '0;
			have_prev_q <= 1'b0;
			last_vel_q  <= '0;
			last_acc_q  <= '0;
			last_jerk_q <= '0;
			warm_q      <= '0;
		end else if (s1_adv) begin
			next_seq_q  <= next_seq_q + 1'b1;
			prev_val_q  <= value_s1;
			have_prev_q <= 1'b1;
			last_vel_q  <= (warm_q != 2'd0) ? velocity : '0;
			last_acc_q  <= warm_q[1] ? accel : '0;
			last_jerk_q <= warm_q[1] ? jerk : '0;
			if (warm_q != 2'd3) begin
				warm_q <= warm_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			dup_s2   <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
			dup_s2   <= dup;
		end else if (valid_s2 && record.ready) begin
			// The first copy leaves and the same record stays for the last one.
			if (dup_s2) begin
				dup_s2 <= 1'b0;
			end else begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			seq_s2   <= next_seq_q;
			value_s2 <= value_s1;
			delta_s2 <= have_prev_q ? delta : '0;
			prev_s2  <= have_prev_q;
		end
	end

	assign record.valid      = valid_s2;
	assign record.seq_number = seq_s2;
	assign record.value_word = value_s2;
	assign record.delta_word = delta_s2;
	assign record.prev_flag  = prev_s2;
	assign record.last_copy  = !dup_s2;

endmodule

### rtl/mtse_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtse_chk
// Port-level checks on the record channel of the encoder, bound to the top.
// ----------------------------------------------------------------------------
module mtse_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rec_valid,
	input logic        rec_ready,
	input logic [15:0] seq_number,
	input logic [15:0] value_word,
	input logic [15:0] delta_word,
	input logic        prev_flag,
	input logic        last_copy
);

	// A stalled record beat stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid)
		else $error("record beat withdrawn while stalled");

	// A stalled record beat keeps its payload.
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> $stable(seq_number) && $stable(value_word)
			&& $stable(delta_word) && $stable(prev_flag) && $stable(last_copy))
		else $error("record payload changed while stalled");

	// The first of two copies is followed at once by its final copy.
	a_dup_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready && !last_copy |=> rec_valid && last_copy
			&& seq_number == $past(seq_number) && value_word == $past(value_word)
			&& delta_word == $past(delta_word))
		else $error("duplicate copy missing or different");

	// A record offered right after a final copy is the next sample's record.
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready && last_copy ##1 rec_valid |->
			seq_number == $past(seq_number) + 16'd1 && prev_flag)
		else $error("sequence number did not advance by one");

	// Without a previous sample the delta word is zero.
	a_first_delta: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !prev_flag |-> delta_word == 16'd0 && seq_number == 16'd0)
		else $error("first record carries a delta or nonzero sequence");

endmodule

bind motion_triggered_sample_encoder mtse_chk u_mtse_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rec_valid  (record.valid),
	.rec_ready  (record.ready),
	.seq_number (record.seq_number),
	.value_word (record.value_word),
	.delta_word (record.delta_word),
	.prev_flag  (record.prev_flag),
	.last_copy  (record.last_copy)
);
